// ===== hdl/b32e_pkg.sv =====
package b32e_pkg;

	localparam int DATA_W   = 8;
	localparam int CHAR_W   = 7;
	localparam int SYM_W    = 5;
	localparam int GROUP_LEN = 8;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

	// Crockford alphabet: 0-9, A-Z without I, L, O, U
	localparam logic [CHAR_W-1:0] CROCKFORD [32] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
		7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4D, 7'h4E, 7'h50, 7'h51,
		7'h52, 7'h53, 7'h54, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A
	};

	// One classified byte: up to three alphabet characters, then padding
	typedef struct packed {
		logic [2:0][CHAR_W-1:0] chars;
		logic [1:0]             n_sym;    // 1..3 alphabet characters
		logic [3:0]             n_total;  // 1..8 characters overall
		logic                   fin;      // closes the message
	} b32e_job_t;

endpackage

// ===== hdl/b32e_byte_if.sv =====
interface b32e_byte_if;
	logic                         valid;
	logic                         ready;
	logic [b32e_pkg::DATA_W-1:0]  data_byte;
	logic                         final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== hdl/b32e_char_if.sv =====
interface b32e_char_if;
	logic                         valid;
	logic                         ready;
	logic [b32e_pkg::CHAR_W-1:0]  symbol_char;
	logic                         last_char;

	modport source (output valid, output symbol_char, output last_char, input ready);
	modport sink   (input valid, input symbol_char, input last_char, output ready);
endinterface

// ===== hdl/b32e_front.sv =====
module b32e_front (
	input  logic                clk,
	input  logic                arst_n,
	b32e_byte_if.sink           bytes,
	output b32e_pkg::b32e_job_t job,
	output logic                push,
	input  logic                q_ready
);
	import b32e_pkg::*;

	logic [3:0]  lbits_q;
	logic [2:0]  lcount_q;
	logic [2:0]  sig_q;

	logic [2:0]  cnt;
	logic [3:0]  lmask;
	logic [11:0] acc;
	logic [3:0]  nbits;
	logic        two;
	logic [3:0]  rem;
	logic [3:0]  remb;
	logic [4:0]  sym0;
	logic [4:0]  sym1;
	logic [4:0]  part;
	logic        has_part;
	logic [1:0]  nsym;
	logic [2:0]  sig_new;
	logic [2:0]  pads;
	logic [3:0]  total;

	assign bytes.ready = q_ready;
	assign push        = bytes.valid && q_ready;

	// split the byte plus leftover bits into 5-bit symbols
	always_comb begin
		cnt      = (lcount_q > 3'd4) ? 3'd4 : lcount_q;
		lmask    = (4'b1 << cnt) - 4'd1;
		acc      = {lbits_q & lmask, bytes.data_byte};
		nbits    = {1'b0, cnt} + 4'd8;
		two      = (nbits >= 4'd10);
		sym0     = 5'(acc >> (nbits - 4'd5));
		sym1     = 5'(acc >> (nbits - 4'd10));
		rem      = two ? (nbits - 4'd10) : (nbits - 4'd5);
		remb     = acc[3:0] & ((4'b1 << rem[2:0]) - 4'd1);
		part     = 5'({1'b0, remb} << (3'd5 - rem[2:0]));
		has_part = bytes.final_byte && (rem != 4'd0);
		nsym     = 2'd1 + {1'b0, two} + {1'b0, has_part};
		sig_new  = sig_q + {1'b0, nsym};
		pads     = bytes.final_byte ? (3'd0 - sig_new) : 3'd0;
		total    = {2'b0, nsym} + {1'b0, pads};
		if (total > 4'(GROUP_LEN))
			total = 4'(GROUP_LEN);

		job.chars[0] = CROCKFORD[sym0];
		job.chars[1] = two ? CROCKFORD[sym1] : CROCKFORD[part];
		job.chars[2] = CROCKFORD[part];
		job.n_sym    = nsym;
		job.n_total  = total;
		job.fin      = bytes.final_byte;
	end

	// stream state, back to reset values after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbits_q  <= '0;
			lcount_q <= '0;
			sig_q    <= '0;
		end else if (push) begin
			if (bytes.final_byte) begin
				lbits_q  <= '0;
				lcount_q <= '0;
				sig_q    <= '0;
			end else begin
				lbits_q  <= remb;
				lcount_q <= rem[2:0];
				sig_q    <= sig_new;
			end
		end
	end

endmodule

// ===== hdl/b32e_queue.sv =====
module b32e_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  b32e_pkg::b32e_job_t wr_job,
	input  logic                push,
	output logic                not_full,
	output b32e_pkg::b32e_job_t rd_job,
	output logic                not_empty,
	input  logic                pop
);
	import b32e_pkg::*;

	b32e_job_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign not_full  = (cnt_q != QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/b32e_back.sv =====
module b32e_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b32e_pkg::b32e_job_t job,
	input  logic                job_valid,
	output logic                pop,
	b32e_char_if.source         chars
);
	import b32e_pkg::*;

	logic [2:0]        idx_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	logic              load;
	logic              at_end;
	logic [CHAR_W-1:0] next_char;

	assign chars.valid       = out_valid_q;
	assign chars.symbol_char = char_q;
	assign chars.last_char   = last_q;

	// pick the current character of the head job
	always_comb begin
		load      = job_valid && (!out_valid_q || chars.ready);
		at_end    = ({1'b0, idx_q} == (job.n_total - 4'd1));
		pop       = load && at_end;
		next_char = (idx_q < {1'b0, job.n_sym}) ? job.chars[idx_q[1:0]] : PAD_CHAR;
	end

	// output register, one character per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_end ? 3'd0 : idx_q + 3'd1;
			end else if (chars.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= next_char;
			last_q <= job.fin && at_end;
		end
	end

endmodule

// ===== hdl/base32_stream_encoder_top.sv =====
// Base32 stream encoder, Crockford alphabet with '=' padding. Bytes enter
// most significant bit first, one per transfer; the byte flagged final
// flushes the partial symbol, pads the 8-character group and marks the last
// character. A byte is accepted whenever the four-entry job queue has room,
// also while a character waits at the output. Characters leave at one per
// cycle from the output register while the receiver is ready; a byte yields
// one or two characters (8 per 5 bytes) and a final byte up to 8, so the
// character serializer limits the rate.
module base32_stream_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	b32e_byte_if.sink   bytes,
	b32e_char_if.source chars
);
	import b32e_pkg::*;

	b32e_job_t wr_job;
	b32e_job_t rd_job;
	logic      push;
	logic      not_full;
	logic      not_empty;
	logic      pop;

	b32e_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes),
		.job     (wr_job),
		.push    (push),
		.q_ready (not_full)
	);

	b32e_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_job    (wr_job),
		.push      (push),
		.not_full  (not_full),
		.rd_job    (rd_job),
		.not_empty (not_empty),
		.pop       (pop)
	);

	b32e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (rd_job),
		.job_valid (not_empty),
		.pop       (pop),
		.chars     (chars)
	);

endmodule

// ===== verif/tb.sv =====
module tb;
	import b32e_pkg::*;

	localparam int    CYCLE_LIMIT   = 250000;
	localparam int    RANDOM_BYTES  = 350;
	localparam int    TAIL_BYTES    = 40;    // no idling once this few bytes remain
	localparam int    HOLD_AT_BYTE  = 120;   // long receiver hold starts here
	localparam int    HOLD_CYCLES   = 150;
	localparam int    SETTLE_CYCLES = 24;
	localparam string B32_ALPHABET  = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
	localparam logic [CHAR_W-1:0] EQ_PAD = 7'h3D;

	typedef struct {
		logic [DATA_W-1:0] data;
		logic              fin;
		logic              drain_first;  // wait for all characters before offering
	} byte_item_t;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	b32e_byte_if bytes_if();
	b32e_char_if chars_if();

	base32_stream_encoder_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_if),
		.chars  (chars_if)
	);

	always #1 clk = ~clk;

	byte_item_t byte_q[$];
	char_exp_t  char_q[$];

	// encoder shadow state
	logic [3:0] carry_bits;
	int         carry_cnt;
	logic [2:0] group_pos;

	int cycles;
	int errors;
	int bytes_sent;
	int msgs_sent;
	int chars_checked;
	int pads_checked;
	int drains_done;
	bit hold_done;

	// driver scratch
	int                tx_gap;
	logic              nxt_valid;
	logic [DATA_W-1:0] nxt_data;
	logic              nxt_fin;

	// monitor scratch
	int        rx_stall;
	int        hold_left;
	logic      nxt_ready;
	char_exp_t exp_c;

	// directed messages: single bytes at both extremes, a full 5-byte group
	// with no padding, then lengths 2, 3, 4 and 6
	localparam int N_DIR = 22;
	logic [DATA_W-1:0] dir_data [N_DIR] = '{
		8'h00, 8'hFF,
		8'hFF, 8'h00, 8'hFF, 8'h00, 8'hA5,
		8'h80, 8'h7F,
		8'h55, 8'hAA, 8'h01,
		8'hFE, 8'h01, 8'h10, 8'hEF,
		8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC
	};
	logic dir_fin [N_DIR] = '{
		1'b1, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b1,
		1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
	};

	function automatic void add_byte(logic [DATA_W-1:0] d, logic f, logic drain);
		byte_item_t it;
		it.data = d;
		it.fin = f;
		it.drain_first = drain;
		byte_q.push_back(it);
	endfunction

	function automatic void push_char(logic [CHAR_W-1:0] ch, ref int n);
		char_exp_t e;
		if (n < GROUP_LEN) begin
			e.ch = ch;
			e.last = 1'b0;
			char_q.push_back(e);
			group_pos = group_pos + 3'd1;
			n++;
		end
	endfunction

	// expected characters for one byte, MSB first, 5 bits per symbol
	function automatic void encode_byte(logic [DATA_W-1:0] b, logic f);
		logic [11:0] acc;
		logic [4:0]  sym;
		int          nbits;
		int          n;
		n = 0;
		acc = ({8'd0, carry_bits} << 8) | {4'd0, b};
		nbits = carry_cnt + 8;
		while (nbits >= 5) begin
			sym = 5'(acc >> (nbits - 5));
			push_char(7'(B32_ALPHABET[sym]), n);
			nbits -= 5;
		end
		acc &= (12'd1 << nbits) - 12'd1;
		if (!f) begin
			carry_bits = acc[3:0];
			carry_cnt = nbits;
		end else begin
			// zero-fill the partial symbol, then pad out the group
			if (nbits > 0) begin
				sym = 5'(acc << (5 - nbits));
				push_char(7'(B32_ALPHABET[sym]), n);
			end
			while (group_pos != 3'd0 && n < GROUP_LEN)
				push_char(EQ_PAD, n);
			if (n > 0)
				char_q[$].last = 1'b1;
			carry_bits = '0;
			carry_cnt = 0;
			group_pos = '0;
		end
	endfunction

	task automatic report_mismatch(string what);
		$display("ERROR @%0d: %s", cycles, what);
		errors++;
	endtask

	// cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters still expected",
				cycles, char_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_if.valid <= 1'b0;
			bytes_if.data_byte <= '0;
			bytes_if.final_byte <= 1'b0;
			tx_gap = 0;
		end else begin
			nxt_valid = bytes_if.valid;
			nxt_data = bytes_if.data_byte;
			nxt_fin = bytes_if.final_byte;
			if (bytes_if.valid && bytes_if.ready) begin
				encode_byte(bytes_if.data_byte, bytes_if.final_byte);
				bytes_sent++;
				if (bytes_if.final_byte)
					msgs_sent++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (byte_q.size() > 0) begin
					if (byte_q[0].drain_first && char_q.size() != 0) begin
						// hold until every expected character has been seen
					end else if (byte_q.size() > TAIL_BYTES && cycles[6]
						&& $urandom_range(0, 4) == 0) begin
						tx_gap = $urandom_range(0, 15);
					end else begin
						if (byte_q[0].drain_first)
							drains_done++;
						nxt_valid = 1'b1;
						nxt_data = byte_q[0].data;
						nxt_fin = byte_q[0].fin;
						void'(byte_q.pop_front());
					end
				end
			end
			bytes_if.valid <= nxt_valid;
			bytes_if.data_byte <= nxt_data;
			bytes_if.final_byte <= nxt_fin;
		end
	end

	// character monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_if.ready <= 1'b0;
			rx_stall = 0;
			hold_left = 0;
		end else begin
			if (chars_if.valid && chars_if.ready) begin
				if (char_q.size() == 0) begin
					report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
						chars_if.symbol_char, chars_if.last_char));
				end else begin
					exp_c = char_q.pop_front();
					chars_checked++;
					if (exp_c.ch == EQ_PAD)
						pads_checked++;
					if (chars_if.symbol_char !== exp_c.ch)
						report_mismatch($sformatf("symbol_char 0x%02h, expected 0x%02h",
							chars_if.symbol_char, exp_c.ch));
					if (chars_if.last_char !== exp_c.last)
						report_mismatch($sformatf("last_char %0b, expected %0b",
							chars_if.last_char, exp_c.last));
				end
			end
			// one long hold so the job queue fills and input backs up
			if (!hold_done && bytes_sent >= HOLD_AT_BYTE) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt_ready = 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				nxt_ready = 1'b0;
			end else if (byte_q.size() > TAIL_BYTES && (cycles[7] ^ cycles[5])
				&& $urandom_range(0, 4) == 0) begin
				rx_stall = $urandom_range(0, 15);
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
			end
			chars_if.ready <= nxt_ready;
		end
	end

	// stimulus, reset and end of run
	initial begin
		int r;
		int len;
		int n_rand;
		logic [DATA_W-1:0] d;
		logic drain;

		bytes_if.valid = 1'b0;
		bytes_if.data_byte = '0;
		bytes_if.final_byte = 1'b0;
		chars_if.ready = 1'b0;
		carry_bits = '0;
		carry_cnt = 0;
		group_pos = '0;
		cycles = 0;
		errors = 0;

		for (int i = 0; i < N_DIR; i++)
			add_byte(dir_data[i], dir_fin[i], 1'b0);

		// random messages, mostly short, a few long
		n_rand = 0;
		while (n_rand < RANDOM_BYTES) begin
			r = $urandom_range(0, 9);
			if (r < 7)
				len = $urandom_range(1, 6);
			else if (r < 9)
				len = $urandom_range(7, 12);
			else
				len = $urandom_range(13, 24);
			drain = (n_rand == 0) || ($urandom_range(0, 15) == 0);
			for (int i = 0; i < len; i++) begin
				r = $urandom_range(0, 9);
				if (r == 0)
					d = 8'h00;
				else if (r == 1)
					d = 8'hFF;
				else
					d = DATA_W'($urandom);
				add_byte(d, i == len - 1, drain && i == 0);
				n_rand++;
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || bytes_if.valid)
			@(posedge clk);
		while (char_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("encoded %0d bytes in %0d messages; %0d characters checked, %0d of them padding",
			bytes_sent, msgs_sent, chars_checked, pads_checked);
		$display("long receiver hold applied: %0b; sender drained %0d times; %0d errors",
			hold_done, drains_done, errors);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
